/* hw/rtl/assert_macros.svh */
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sfdh_pkg.sv */
package sfdh_pkg;

    // Fixed widths and sizes
    localparam int COEF_FRAC_BITS_DEF = 24;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 32;
    localparam int PROD_W       = SAMPLE_W + 1 + COEF_W;
    localparam int ACC_W        = 56;
    localparam int LP_HALF      = 31;   // folded low-pass taps
    localparam int LP_HIST      = 60;
    localparam int ADDR_W       = 6;
    localparam int TAP_W        = 5;
    localparam int HP_TAPS      = 5;
    localparam int HP_HIST      = 4;
    localparam int HP_IDX_W     = 2;
    localparam int HP_TAP_IDX_W = 3;
    localparam int DRAIN_CYC    = 2;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_INVERT_LEFT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWAP_CHANNELS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DECIMATE      = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef t_coef t_lp_tab [LP_HALF];
    typedef t_coef t_hp_tab [HP_TAPS];

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Decimal coefficients scaled by 1e14
    localparam longint unsigned DEC_SCALE = 64'd100000000000000;
    localparam longint LP_DEC [LP_HALF] = '{
        -64'sd7507, -64'sd763429300, -64'sd4041223300, 64'sd1971907300,
        64'sd20377662000, 64'sd13767974000, -64'sd40439283000, -64'sd66447260000,
        64'sd29251078000, 64'sd153570750000, 64'sd67007710000,
        -64'sd221148090000, -64'sd283535780000, 64'sd155079780000,
        64'sd575083080000, 64'sd176655350000, -64'sd765895660000,
        -64'sd823938200000, 64'sd564104100000, 64'sd1634167500000,
        64'sd329197220000, -64'sd2180879600000, -64'sd2045659200000,
        64'sd1784535700000, 64'sd4400624000000, 64'sd468221960000,
        -64'sd6873457000000, -64'sd6387941500000, 64'sd8764380000000,
        64'sd30289385000000, 64'sd40517990000000
    };
    localparam longint HP_DEC [HP_TAPS] = '{
        64'sd10000000000000, -64'sd40000000000000, 64'sd60000000000000,
        -64'sd40000000000000, 64'sd10000000000000
    };

    // Command and status between controller and datapath
    typedef struct packed {
        logic             accept;
        logic             issue;
        logic             clr;
        logic             src_hp;
        logic [TAP_W-1:0] tap;
        logic             lp_fin;
        logic             mix;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic phase;
        logic out_free;
    } t_stat;

    // Scale a decimal coefficient to fixed point, halves away from zero
    function automatic longint quantize(input longint c, input int frac);
        longint unsigned mag;
        longint unsigned rem;
        longint unsigned q;
        int i;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        rem = mag % DEC_SCALE;
        q   = mag / DEC_SCALE;
        for (i = 0; i < frac; i++) begin
            q   = q << 1;
            rem = rem << 1;
            if (rem >= DEC_SCALE) begin
                rem = rem - DEC_SCALE;
                q   = q + 64'd1;
            end
        end
        if (rem * 2 >= DEC_SCALE) q = q + 64'd1;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_lp_tab lp_table(input int frac);
        t_lp_tab t;
        int k;
        for (k = 0; k < LP_HALF; k++) t[k] = COEF_W'(quantize(LP_DEC[k], frac));
        return t;
    endfunction

    function automatic t_hp_tab hp_table(input int frac);
        t_hp_tab t;
        int k;
        for (k = 0; k < HP_TAPS; k++) t[k] = COEF_W'(quantize(HP_DEC[k], frac));
        return t;
    endfunction

endpackage

/* hw/rtl/sfdh_ctrl.sv */
module sfdh_ctrl import sfdh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_decim,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LP_RUN   = 3'd1;
    localparam logic [2:0] S_LP_DRAIN = 3'd2;
    localparam logic [2:0] S_LP_FIN   = 3'd3;
    localparam logic [2:0] S_MIX      = 3'd4;
    localparam logic [2:0] S_HP_RUN   = 3'd5;
    localparam logic [2:0] S_HP_DRAIN = 3'd6;
    localparam logic [2:0] S_HP_FIN   = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [TAP_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence the taps and the finishing steps
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.tap = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                n_cnt = '0;
                if (i_in_valid) n_state = i_decim ? S_LP_RUN : S_MIX;
            end
            S_LP_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.clr   = (r_cnt == '0);
                if (r_cnt == TAP_W'(LP_HALF - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LP_DRAIN;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_LP_DRAIN: begin
                if (r_cnt == TAP_W'(DRAIN_CYC - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LP_FIN;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_LP_FIN: begin
                o_cmd.lp_fin = 1'b1;
                // second of a pair goes on to the high-pass
                n_state = i_stat.phase ? S_MIX : S_IDLE;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_cnt     = '0;
                n_state   = S_HP_RUN;
            end
            S_HP_RUN: begin
                o_cmd.issue  = 1'b1;
                o_cmd.src_hp = 1'b1;
                o_cmd.clr    = (r_cnt == '0);
                if (r_cnt == TAP_W'(HP_TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_HP_DRAIN;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_HP_DRAIN: begin
                if (r_cnt == TAP_W'(DRAIN_CYC - 1)) begin
                    n_cnt   = '0;
                    n_state = S_HP_FIN;
                end else begin
                    n_cnt = r_cnt + TAP_W'(1);
                end
            end
            S_HP_FIN: begin
                // hold until the output register is free
                o_cmd.out_load = i_stat.out_free;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* hw/rtl/sfdh_dp.sv */
module sfdh_dp import sfdh_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  logic    i_invert_left,
    input  logic    i_swap_channels,
    input  logic    i_decim,
    input  t_sample i_left_in,
    input  t_sample i_right_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_sample o_left_out,
    output t_sample o_right_out
);

    localparam t_lp_tab LP_COEF  = lp_table(COEF_FRAC_BITS);
    localparam t_hp_tab HP_COEF  = hp_table(COEF_FRAC_BITS);
    localparam t_acc    HALF     = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam t_acc    RND_MASK = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
    localparam t_acc    ACC_MAX  = ACC_W'(SAMPLE_MAX);
    localparam t_acc    ACC_MIN  = ACC_W'(SAMPLE_MIN);

    // Shift right toward zero after adding off, then clamp to 16 bits
    function automatic t_sample trunc_sat(input t_acc v, input t_acc off);
        t_acc    s;
        t_acc    q;
        logic    neg;
        t_sample res;
        neg = (v < -off);
        s   = v + (neg ? off + RND_MASK : off);
        q   = s >>> COEF_FRAC_BITS;
        if (q > ACC_MAX)      res = SAMPLE_MAX;
        else if (q < ACC_MIN) res = SAMPLE_MIN;
        else                  res = t_sample'(q);
        return res;
    endfunction

    // Input item
    t_sample r_xl, r_xr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xl <= i_left_in;
            r_xr <= i_right_in;
        end
    end

    // Low-pass history: circular buffer, left in the upper half of a word
    logic [2*SAMPLE_W-1:0] mem [LP_HIST];
    logic [LP_HIST-1:0]    r_valid;
    logic [ADDR_W-1:0]     r_wptr;
    logic [ADDR_W:0]       w_sum_a;
    logic [ADDR_W-1:0]     w_addr_a, w_addr_b;
    logic [2*SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic                  r_va, r_vb;

    assign w_sum_a  = {1'b0, r_wptr} + (ADDR_W+1)'(i_cmd.tap);
    assign w_addr_a = (w_sum_a >= (ADDR_W+1)'(LP_HIST)) ?
                      ADDR_W'(w_sum_a - (ADDR_W+1)'(LP_HIST)) : ADDR_W'(w_sum_a);
    assign w_addr_b = (r_wptr >= ADDR_W'(i_cmd.tap)) ? (r_wptr - ADDR_W'(i_cmd.tap)) :
                      ADDR_W'({1'b0, r_wptr} + (ADDR_W+1)'(LP_HIST) -
                              (ADDR_W+1)'(i_cmd.tap));

    always_ff @(posedge i_clk) begin
        if (i_cmd.lp_fin) mem[r_wptr] <= {r_xl, r_xr};
        if (i_cmd.issue) begin
            r_rd_a <= mem[w_addr_a];
            r_rd_b <= mem[w_addr_b];
            r_va   <= r_valid[w_addr_a];
            r_vb   <= r_valid[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wptr  <= '0;
        end else if (i_cmd.lp_fin) begin
            r_valid[r_wptr] <= 1'b1;
            r_wptr <= (r_wptr == ADDR_W'(LP_HIST - 1)) ? '0 : r_wptr + ADDR_W'(1);
        end
    end

    // Pipeline control
    logic             r_s1_vld, r_s1_clr, r_s1_hp, r_s2_vld, r_s2_clr;
    logic [TAP_W-1:0] r_s1_tap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_clr <= i_cmd.clr;
        r_s1_hp  <= i_cmd.src_hp;
        r_s1_tap <= i_cmd.tap;
        r_s2_clr <= r_s1_clr;
    end

    // Operand select and pre-add of the folded taps
    t_sample              r_yl, r_yr;
    t_sample              r_hpl [HP_HIST];
    t_sample              r_hpr [HP_HIST];
    logic [TAP_W-1:0]     w_hp_prev;
    t_sample              w_al, w_ar, w_bl, w_br;
    logic signed [SAMPLE_W:0] w_op_l, w_op_r;
    t_coef                w_coef;
    logic signed [PROD_W-1:0] w_prod_l, w_prod_r, r_pl, r_pr;

    assign w_hp_prev = r_s1_tap - TAP_W'(1);

    always_comb begin
        if (r_s1_hp) begin
            w_al   = '0;
            w_ar   = '0;
            w_bl   = (r_s1_tap == '0) ? r_yl : r_hpl[w_hp_prev[HP_IDX_W-1:0]];
            w_br   = (r_s1_tap == '0) ? r_yr : r_hpr[w_hp_prev[HP_IDX_W-1:0]];
            w_coef = HP_COEF[r_s1_tap[HP_TAP_IDX_W-1:0]];
        end else begin
            w_al = r_va ? t_sample'(r_rd_a[2*SAMPLE_W-1:SAMPLE_W]) : '0;
            w_ar = r_va ? t_sample'(r_rd_a[SAMPLE_W-1:0]) : '0;
            // newest tap is the input; the middle tap counts once
            if (r_s1_tap == '0) begin
                w_bl = r_xl;
                w_br = r_xr;
            end else if (r_s1_tap == TAP_W'(LP_HALF - 1) || !r_vb) begin
                w_bl = '0;
                w_br = '0;
            end else begin
                w_bl = t_sample'(r_rd_b[2*SAMPLE_W-1:SAMPLE_W]);
                w_br = t_sample'(r_rd_b[SAMPLE_W-1:0]);
            end
            w_coef = LP_COEF[r_s1_tap];
        end
    end

    assign w_op_l   = (SAMPLE_W+1)'(w_al) + (SAMPLE_W+1)'(w_bl);
    assign w_op_r   = (SAMPLE_W+1)'(w_ar) + (SAMPLE_W+1)'(w_br);
    assign w_prod_l = w_op_l * w_coef;
    assign w_prod_r = w_op_r * w_coef;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_pl <= w_prod_l;
            r_pr <= w_prod_r;
        end
    end

    // Accumulate
    t_acc r_acc_l, r_acc_r;
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc_l <= r_s2_clr ? ACC_W'(r_pl) : r_acc_l + ACC_W'(r_pl);
            r_acc_r <= r_s2_clr ? ACC_W'(r_pr) : r_acc_r + ACC_W'(r_pr);
        end
    end

    // Finish the low-pass: hold the first of a pair, keep the second
    t_sample r_held_l, r_held_r, r_fl, r_fr;
    logic    r_phase;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_held_l <= '0;
            r_held_r <= '0;
        end else if (i_cmd.lp_fin) begin
            r_phase <= ~r_phase;
            if (!r_phase) begin
                r_held_l <= trunc_sat(r_acc_l, HALF);
                r_held_r <= trunc_sat(r_acc_r, HALF);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lp_fin && r_phase) begin
            r_fl <= trunc_sat(r_acc_l, HALF);
            r_fr <= trunc_sat(r_acc_r, HALF);
        end
    end

    // Average the pair when decimating, else take the input item; then invert and swap
    logic signed [SAMPLE_W:0] w_sum_l, w_sum_r, w_adj_l, w_adj_r;
    t_sample w_src_l, w_src_r, w_inv_l;

    assign w_sum_l = (SAMPLE_W+1)'(r_held_l) + (SAMPLE_W+1)'(r_fl);
    assign w_sum_r = (SAMPLE_W+1)'(r_held_r) + (SAMPLE_W+1)'(r_fr);
    assign w_adj_l = w_sum_l + $signed({{SAMPLE_W{1'b0}}, w_sum_l[SAMPLE_W]});
    assign w_adj_r = w_sum_r + $signed({{SAMPLE_W{1'b0}}, w_sum_r[SAMPLE_W]});
    assign w_src_l = i_decim ? t_sample'(w_adj_l >>> 1) : r_xl;
    assign w_src_r = i_decim ? t_sample'(w_adj_r >>> 1) : r_xr;
    assign w_inv_l = (i_invert_left && w_src_l != SAMPLE_MIN) ? t_sample'(-w_src_l) : w_src_l;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_yl <= i_swap_channels ? w_src_r : w_inv_l;
            r_yr <= i_swap_channels ? w_inv_l : w_src_r;
        end
    end

    // High-pass history advances as the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HP_HIST; k++) begin
                r_hpl[k] <= '0;
                r_hpr[k] <= '0;
            end
        end else if (i_cmd.out_load) begin
            r_hpl[0] <= r_yl;
            r_hpr[0] <= r_yr;
            for (int k = 1; k < HP_HIST; k++) begin
                r_hpl[k] <= r_hpl[k-1];
                r_hpr[k] <= r_hpr[k-1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_left_out  <= trunc_sat(r_acc_l, '0);
            o_right_out <= trunc_sat(r_acc_r, '0);
        end
    end

    assign o_stat.phase    = r_phase;
    assign o_stat.out_free = !o_out_valid || i_out_ready;

endmodule

/* hw/rtl/stereo_fir_decimate_highpass.sv */
// Channel   Handshake                      Payload
// input     i_in_valid / o_in_ready        i_left_in, i_right_in (s16)
// output    o_out_valid / i_out_ready      o_left_out, o_right_out (s16)
// config    psel, penable, pwrite, pready  paddr[3:0], pwdata, prdata (32 bits)
//
// Decimate mode: two multipliers (one per channel) sweep 31 folded low-pass taps, then
// 5 high-pass taps for the second item of a pair, each through a two-stage
// multiply-accumulate pipeline. Pass-through runs only the high-pass taps.
// A finished result waits in the output register; the next item is accepted meanwhile
// and only its final load waits for the register to free up.
// Synchronous active-low reset clears the histories, phase, held pair and registers.
`include "assert_macros.svh"

module stereo_fir_decimate_highpass import sfdh_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_sample            i_left_in,
    input  t_sample            i_right_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_sample            o_left_out,
    output t_sample            o_right_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic r_invert_left, r_swap_channels, r_decimate;
    logic [REG_IDX_W-1:0] w_reg_idx;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];

    // Write configuration on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_left   <= 1'b0;
            r_swap_channels <= 1'b0;
            r_decimate      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_INVERT_LEFT:   r_invert_left   <= pwdata[0];
                REG_SWAP_CHANNELS: r_swap_channels <= pwdata[0];
                REG_DECIMATE:      r_decimate      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_reg_idx)
            REG_INVERT_LEFT:   prdata = {{(PDATA_W-1){1'b0}}, r_invert_left};
            REG_SWAP_CHANNELS: prdata = {{(PDATA_W-1){1'b0}}, r_swap_channels};
            REG_DECIMATE:      prdata = {{(PDATA_W-1){1'b0}}, r_decimate};
            default:           prdata = '0;
        endcase
    end

    sfdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_decim    (r_decimate),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sfdh_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_invert_left   (r_invert_left),
        .i_swap_channels (r_swap_channels),
        .i_decim         (r_decimate),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out)
    );

    // Checks
    `ASSERT_IMPLIES(a_load_into_free, i_clk, i_rst_n, w_cmd.out_load, w_stat.out_free, "result loaded over a pending one")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held after accepting an item")
    `ASSERT_NEXT(a_first_of_pair_idle, i_clk, i_rst_n, w_cmd.lp_fin && !w_stat.phase, o_in_ready, "first item of a pair did not return to idle")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top import sfdh_pkg::*; ();

    localparam int FRAC          = COEF_FRAC_BITS_DEF;
    localparam int LP_TAPS       = LP_HIST + 1;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int ITEM_GOAL     = 1950;
    localparam longint HALF      = longint'(1) << (FRAC - 1);
    localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_pair;

    typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_HOLD} t_sink_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_in_ready;
    t_sample            left_in;
    t_sample            right_in;
    logic               o_out_valid;
    logic               out_ready;
    t_sample            o_left_out;
    t_sample            o_right_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Filter coefficients in fixed point, and the decimal values they come from
    longint lp_dec  [LP_HALF];
    longint hp_dec  [HP_TAPS];
    longint lp_coef [LP_HALF];
    longint hp_coef [HP_TAPS];

    // Predicted block state, channel 0 left and 1 right
    t_sample lp_hist [2][LP_HIST];
    t_sample hp_hist [2][HP_HIST];
    bit      dec_phase;
    t_sample held_l;
    t_sample held_r;
    bit      cfg_invert;
    bit      cfg_swap;
    bit      cfg_decimate;

    t_pair      expected_pairs [$];
    t_pair      want_pair;
    int         items_sent;
    int         results_seen;
    int         reg_writes;
    int         errors;
    int         burst_left;
    int         cycle_count;
    t_sink_mode sink_mode;
    int         sink_run;

    stereo_fir_decimate_highpass u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (left_in),
        .i_right_in  (right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Round c / 1e14 * 2^FRAC to nearest, halves away from zero
    function automatic longint fixed_coef(input longint c);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] scale;
        longint unsigned mag;
        scale = 128'd100000000000000;
        mag   = (c < 0) ? longint'(-c) : longint'(c);
        num   = {64'd0, mag} << FRAC;
        q     = num / scale;
        r     = num % scale;
        if ((r << 1) >= scale) q = q + 128'd1;
        return (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_sample trunc_sat(input longint v);
        longint q;
        if (v < 0) q = -((-v) >> FRAC);
        else q = v >> FRAC;
        if (q > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
        if (q < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
        return t_sample'(q);
    endfunction

    // Low-pass sum for one channel; shift the new sample into its history
    function automatic longint lp_step(input int ch, input t_sample x);
        longint acc;
        int k;
        int idx;
        acc = lp_coef[0] * longint'(x);
        for (k = 1; k < LP_TAPS; k++) begin
            idx = (k < LP_HALF) ? k : (LP_TAPS - 1 - k);
            acc += lp_coef[idx] * longint'(lp_hist[ch][k-1]);
        end
        for (k = LP_HIST - 1; k > 0; k--) lp_hist[ch][k] = lp_hist[ch][k-1];
        lp_hist[ch][0] = x;
        return acc;
    endfunction

    function automatic t_sample hp_step(input int ch, input t_sample x);
        longint acc;
        int k;
        acc = hp_coef[0] * longint'(x);
        for (k = 1; k < HP_TAPS; k++) acc += hp_coef[k] * longint'(hp_hist[ch][k-1]);
        for (k = HP_HIST - 1; k > 0; k--) hp_hist[ch][k] = hp_hist[ch][k-1];
        hp_hist[ch][0] = x;
        return trunc_sat(acc);
    endfunction

    task automatic reset_model();
        int k;
        lp_dec = '{
            -64'sd7507, -64'sd763429300, -64'sd4041223300, 64'sd1971907300,
            64'sd20377662000, 64'sd13767974000, -64'sd40439283000, -64'sd66447260000,
            64'sd29251078000, 64'sd153570750000, 64'sd67007710000,
            -64'sd221148090000, -64'sd283535780000, 64'sd155079780000,
            64'sd575083080000, 64'sd176655350000, -64'sd765895660000,
            -64'sd823938200000, 64'sd564104100000, 64'sd1634167500000,
            64'sd329197220000, -64'sd2180879600000, -64'sd2045659200000,
            64'sd1784535700000, 64'sd4400624000000, 64'sd468221960000,
            -64'sd6873457000000, -64'sd6387941500000, 64'sd8764380000000,
            64'sd30289385000000, 64'sd40517990000000
        };
        hp_dec = '{
            64'sd10000000000000, -64'sd40000000000000, 64'sd60000000000000,
            -64'sd40000000000000, 64'sd10000000000000
        };
        for (k = 0; k < LP_HALF; k++) lp_coef[k] = fixed_coef(lp_dec[k]);
        for (k = 0; k < HP_TAPS; k++) hp_coef[k] = fixed_coef(hp_dec[k]);
        for (k = 0; k < LP_HIST; k++) begin
            lp_hist[0][k] = '0;
            lp_hist[1][k] = '0;
        end
        for (k = 0; k < HP_HIST; k++) begin
            hp_hist[0][k] = '0;
            hp_hist[1][k] = '0;
        end
        dec_phase    = 1'b0;
        held_l       = '0;
        held_r       = '0;
        cfg_invert   = 1'b0;
        cfg_swap     = 1'b0;
        cfg_decimate = 1'b0;
    endtask

    // Advance the predicted state by one input item; queue the output item, if it causes one
    task automatic predict_pair(input t_sample l_in, input t_sample r_in);
        t_sample l;
        t_sample r;
        t_sample fl;
        t_sample fr;
        t_sample t;
        t_pair   p;
        l = l_in;
        r = r_in;
        if (cfg_decimate) begin
            fl = trunc_sat(lp_step(0, l) + HALF);
            fr = trunc_sat(lp_step(1, r) + HALF);
            if (!dec_phase) begin
                held_l    = fl;
                held_r    = fr;
                dec_phase = 1'b1;
                return;
            end
            dec_phase = 1'b0;
            l = t_sample'((int'(held_l) + int'(fl)) / 2);
            r = t_sample'((int'(held_r) + int'(fr)) / 2);
        end
        if (cfg_invert && l != SAMPLE_MIN) l = -l;
        if (cfg_swap) begin
            t = l;
            l = r;
            r = t;
        end
        p.left  = hp_step(0, l);
        p.right = hp_step(1, r);
        expected_pairs.push_back(p);
    endtask

    // Check output items and stall the output on a pattern of its own
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_pairs.size() == 0) begin
                $error("unexpected output item: left_out %0d, right_out %0d",
                       o_left_out, o_right_out);
                errors++;
            end else begin
                want_pair = expected_pairs.pop_front();
                if (o_left_out !== want_pair.left) begin
                    $error("left_out: expected %0d, actual %0d", want_pair.left, o_left_out);
                    errors++;
                end
                if (o_right_out !== want_pair.right) begin
                    $error("right_out: expected %0d, actual %0d", want_pair.right, o_right_out);
                    errors++;
                end
            end
        end
        if (sink_run == 0) begin
            case ($urandom_range(0, 3))
                0, 1:    sink_mode = SINK_OPEN;
                2:       sink_mode = SINK_CHOPPY;
                default: sink_mode = SINK_HOLD;
            endcase
            sink_run = (sink_mode == SINK_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 60);
        end
        sink_run--;
        case (sink_mode)
            SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
            SINK_HOLD:   out_ready <= 1'b0;
            default:     out_ready <= 1'b1;
        endcase
    end

    // Send one item, in bursts with random gaps between them
    task automatic send_pair(input t_sample l, input t_sample r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pair(l, r);
        items_sent++;
    endtask

    // Hold the input until every queued output item has come
    task automatic wait_results();
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let the block finish any item that has no output
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup phase, then access until pready; junk in the upper bits
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input bit val);
        logic [PDATA_W-1:0] data;
        data    = $urandom;
        data[0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        case (idx)
            REG_INVERT_LEFT:   cfg_invert   = val;
            REG_SWAP_CHANNELS: cfg_swap     = val;
            REG_DECIMATE:      cfg_decimate = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input bit inv, input bit swp, input bit dec);
        write_reg(REG_INVERT_LEFT, inv);
        write_reg(REG_SWAP_CHANNELS, swp);
        write_reg(REG_DECIMATE, dec);
    endtask

    function automatic t_sample rand_sample(input int kind);
        if (kind < 10) return t_sample'($urandom);
        if (kind < 14) return t_sample'($urandom_range(0, 200) - 100);
        case ($urandom_range(0, 4))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return t_sample'(0);
            3:       return t_sample'(-1);
            default: return t_sample'(1);
        endcase
    endfunction

    // One run of random items: noise, small values, extremes, or shaped sequences
    task automatic send_chunk();
        int kind;
        int n;
        int j;
        int amp;
        int idx;
        t_sample l;
        kind = $urandom_range(0, 19);
        if (kind == 19) begin
            // follow the low-pass coefficient signs to drive its sum out of range
            amp = $urandom_range(20000, 32767);
            for (j = 0; j < LP_TAPS; j++) begin
                idx = (j < LP_HALF) ? j : (LP_TAPS - 1 - j);
                l = (lp_coef[idx] < 0) ? t_sample'(-amp) : t_sample'(amp);
                send_pair(l, $urandom_range(0, 1) ? l : -l);
            end
        end else if (kind >= 17) begin
            // full-scale alternation saturates the high-pass
            n = $urandom_range(4, 12);
            for (j = 0; j < n; j++) begin
                if (j % 2 == 0) send_pair(SAMPLE_MAX, SAMPLE_MIN);
                else send_pair(SAMPLE_MIN, SAMPLE_MAX);
            end
        end else begin
            n = $urandom_range(1, 20);
            for (j = 0; j < n; j++) send_pair(rand_sample(kind), rand_sample(kind));
        end
    endtask

    // Reset values first, then pass-through extremes and high-pass saturation
    task automatic test_passthrough();
        send_pair(t_sample'(0), t_sample'(0));
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        settle();
        write_all(1'b0, 1'b0, 1'b0);
        send_pair(t_sample'(1), t_sample'(-1));
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(t_sample'(-1), t_sample'(1));
        settle();
    endtask

    // Inversion of the most negative sample, swap, and both together
    task automatic test_invert_swap();
        write_all(1'b1, 1'b0, 1'b0);
        send_pair(SAMPLE_MIN, t_sample'(5));
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        settle();
        write_all(1'b0, 1'b1, 1'b0);
        send_pair(t_sample'(100), t_sample'(-200));
        settle();
        write_all(1'b1, 1'b1, 1'b0);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(t_sample'(-7), t_sample'(7));
        settle();
    endtask

    task automatic test_decimate();
        write_all(1'b0, 1'b0, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(t_sample'(12345), t_sample'(-12345));
        send_pair(t_sample'(-1), t_sample'(1));
        settle();
    endtask

    // Leave a pair half done, switch decimation off and on, and expect it to resume;
    // a write past the last register must change nothing
    task automatic test_decimate_resume();
        write_reg(REG_NONE, 1'b1);
        send_pair(t_sample'(3000), t_sample'(-3000));
        send_pair(t_sample'(-20000), t_sample'(20000));
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        settle();
        write_reg(REG_DECIMATE, 1'b0);
        send_pair(t_sample'(777), t_sample'(-777));
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        settle();
        write_reg(REG_DECIMATE, 1'b1);
        send_pair(t_sample'(-32000), t_sample'(32000));
        send_pair(t_sample'(0), t_sample'(0));
        send_pair(t_sample'(16384), t_sample'(-16384));
        settle();
    endtask

    // Random settings per segment; once per segment hold the input until drained
    task automatic test_random();
        int  goal;
        int  pause_at;
        bit  paused;
        while (items_sent < ITEM_GOAL) begin
            settle();
            write_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            goal     = items_sent + $urandom_range(60, 220);
            pause_at = items_sent + $urandom_range(10, 50);
            paused   = 1'b0;
            while (items_sent < goal) begin
                send_chunk();
                if (!paused && items_sent >= pause_at) begin
                    wait_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n    <= 1'b0;
        in_valid   <= 1'b0;
        left_in    <= '0;
        right_in   <= '0;
        out_ready  <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        items_sent   = 0;
        results_seen = 0;
        reg_writes   = 0;
        errors       = 0;
        burst_left   = 0;
        cycle_count  = 0;
        sink_mode    = SINK_OPEN;
        sink_run     = 0;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_invert_swap();
        test_decimate();
        test_decimate_resume();
        test_random();
        settle();

        $display("Sent %0d sample pairs, checked %0d filtered pairs, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("Covered pass-through and decimation with inversion and swap, under stalls");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* stereo_fir_decimate_highpass.f */
+incdir+hw/rtl
hw/rtl/sfdh_pkg.sv
hw/rtl/sfdh_ctrl.sv
hw/rtl/sfdh_dp.sv
hw/rtl/stereo_fir_decimate_highpass.sv
tb/sv/tb_top.sv
